/* hw/rtl/hcd_pkg.sv */
// shared types and codes for the chunked body decoder
// no dependencies; imported by every module of the block
`default_nettype none

package hcd_pkg;

    // result kinds
    localparam logic [1:0] K_DATA  = 2'd0;
    localparam logic [1:0] K_END   = 2'd1;
    localparam logic [1:0] K_BAD   = 2'd2;
    localparam logic [1:0] K_TRUNC = 2'd3;

    // framing characters
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    // result queue depth
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // one result word
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  kind;
        logic [31:0] total_length;
        logic        run_last;
    } t_res;

    // what the parser reports for the byte it is handed
    typedef struct packed {
        logic        has_prim;   // data, end or bad result
        logic [7:0]  prim_data;
        logic [1:0]  prim_kind;
        logic [31:0] prim_total;
        logic        trunc;      // truncated result follows
        logic [31:0] trunc_total;
    } t_step;

endpackage

`default_nettype wire

/* hw/rtl/hcd_parse.sv */
// size line / data phase tracker of the chunked body decoder
// depends on hcd_pkg
`default_nettype none

module hcd_parse
    import hcd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_proc,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last_byte,
    output t_step           o_step
);

    localparam logic [1:0] PH_SIZE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] PH_FAIL = 2'd3;

    localparam logic [3:0] DigitLimit = 4'(MAX_SIZE_DIGITS);

    logic [1:0]  r_phase, n_phase;
    logic        r_cr, n_cr;
    logic [3:0]  r_dcnt, n_dcnt;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_left, n_left;
    logic [31:0] r_cnt, n_cnt;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [31:0] cnt_inc;
    logic        bad;

    // hex digit decode
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            hex_val = 4'(i_in_byte - 8'h30);
        end else if (i_in_byte >= 8'h41 && i_in_byte <= 8'h46) begin
            hex_val = 4'(i_in_byte - 8'h41 + 8'd10);
        end else if (i_in_byte >= 8'h61 && i_in_byte <= 8'h66) begin
            hex_val = 4'(i_in_byte - 8'h61 + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cnt_inc = (r_cnt == 32'hffff_ffff) ? r_cnt : r_cnt + 32'd1;

    always_comb begin
        n_phase = r_phase;
        n_cr    = r_cr;
        n_dcnt  = r_dcnt;
        n_acc   = r_acc;
        n_left  = r_left;
        n_cnt   = r_cnt;
        bad     = 1'b0;

        o_step            = '0;
        o_step.prim_total = r_cnt;

        case (r_phase)
            PH_DATA: begin
                n_cnt             = cnt_inc;
                o_step.has_prim   = 1'b1;
                o_step.prim_kind  = K_DATA;
                o_step.prim_data  = i_in_byte;
                o_step.prim_total = cnt_inc;
                n_left            = r_left - 32'd1;
                if (n_left == 32'd0) begin
                    n_phase = PH_SIZE;
                    n_cr    = 1'b0;
                    n_dcnt  = 4'd0;
                    n_acc   = 32'd0;
                end
            end
            PH_SIZE: begin
                if (r_cr) begin
                    if (i_in_byte == CH_LF) begin
                        if (r_dcnt == 4'd0) begin
                            // empty line
                            n_cr = 1'b0;
                        end else if (r_acc == 32'd0) begin
                            o_step.has_prim  = 1'b1;
                            o_step.prim_kind = K_END;
                            n_phase          = PH_DONE;
                        end else begin
                            n_left  = r_acc;
                            n_phase = PH_DATA;
                            n_cr    = 1'b0;
                            n_dcnt  = 4'd0;
                            n_acc   = 32'd0;
                        end
                    end else begin
                        bad = 1'b1;   // lone cr
                    end
                end else if (i_in_byte == CH_CR) begin
                    n_cr = 1'b1;
                end else if (!hex_ok || r_dcnt >= DigitLimit) begin
                    bad = 1'b1;
                end else begin
                    n_acc  = {r_acc[27:0], hex_val};
                    n_dcnt = r_dcnt + 4'd1;
                end
                if (bad) begin
                    o_step.has_prim  = 1'b1;
                    o_step.prim_kind = K_BAD;
                    n_phase          = PH_FAIL;
                end
            end
            default: begin
                // done or failed: swallow bytes until the body ends
            end
        endcase

        o_step.trunc_total = n_cnt;
        o_step.trunc       = i_last_byte && (n_phase == PH_SIZE || n_phase == PH_DATA);

        if (i_last_byte) begin
            n_phase = PH_SIZE;
            n_cr    = 1'b0;
            n_dcnt  = 4'd0;
            n_acc   = 32'd0;
            n_left  = 32'd0;
            n_cnt   = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_cr    <= 1'b0;
            r_dcnt  <= 4'd0;
            r_acc   <= 32'd0;
            r_left  <= 32'd0;
            r_cnt   <= 32'd0;
        end else if (i_proc) begin
            r_phase <= n_phase;
            r_cr    <= n_cr;
            r_dcnt  <= n_dcnt;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hcd_outq.sv */
// small result queue that decouples the parser from output stalls
// depends on hcd_pkg
`default_nettype none

module hcd_outq
    import hcd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_res      i_word,
    output logic      o_room,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_res      o_word
);

    t_res             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt, n_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt != (QAW+1)'(QDEPTH));
    assign pop     = o_valid && !i_stall;
    assign o_word  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/http_chunked_decoder.sv */
// top level of the http chunked transfer decoder
// depends on hcd_pkg, hcd_parse, hcd_outq
// usage:
//   input channel: one body byte per word (i_in_byte, i_last_byte) on
//   i_valid / o_stall; a word is taken at a rising edge with i_valid high
//   and o_stall low. i_last_byte marks the final byte of a body, after
//   which the decoder is back in its reset state for the next body.
//   output channel: result words (o_data_byte, o_kind, o_total_length,
//   o_run_last) on o_valid / i_stall. kinds are data, end of body at the
//   zero chunk, bad size line, and truncated body. a byte yields zero,
//   one or two words; o_run_last marks the last word of a byte.
//   path: a byte taken passes the input register, then the result queue,
//   before its first result word is on the output.
//   throughput: one byte per cycle while the queue has room; a byte that
//   yields two words (the truncation word behind a data word) holds the
//   input while the second word is queued.
//   output stalls: the two-entry result queue absorbs them; o_stall rises
//   while the input register holds a byte and the queue is full or a
//   truncation word is still waiting.
//   reset: synchronous, active low; clears parser state, queue, input reg.
`default_nettype none

module http_chunked_decoder
    import hcd_pkg::*;
#(
    parameter int MAX_SIZE_DIGITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last_byte,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_data_byte,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_total_length,
    output logic             o_run_last
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // truncation word waiting behind a data word
    logic        r_pend;
    logic [31:0] r_pend_total;

    logic        room;
    logic        proc;
    logic        accept;
    logic        push;
    t_res        push_word;
    t_res        out_word;
    t_step       step;

    // parse only when the queue can take a word and no truncation is waiting
    assign proc    = r_in_valid && !r_pend && room;
    assign o_stall = r_in_valid && !proc;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    hcd_parse #(
        .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (proc),
        .i_in_byte   (r_in_byte),
        .i_last_byte (r_in_last),
        .o_step      (step)
    );

    // queue write: pending truncation first, else this byte's first word
    always_comb begin
        push      = 1'b0;
        push_word = '0;
        if (r_pend) begin
            push                   = room;
            push_word.kind         = K_TRUNC;
            push_word.total_length = r_pend_total;
            push_word.run_last     = 1'b1;
        end else if (proc && step.has_prim) begin
            push                   = 1'b1;
            push_word.data_byte    = step.prim_data;
            push_word.kind         = step.prim_kind;
            push_word.total_length = step.prim_total;
            push_word.run_last     = !step.trunc;
        end else if (proc && step.trunc) begin
            push                   = 1'b1;
            push_word.kind         = K_TRUNC;
            push_word.total_length = step.trunc_total;
            push_word.run_last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && step.has_prim && step.trunc) begin
            r_pend_total <= step.trunc_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (r_pend && room) begin
            r_pend <= 1'b0;
        end else if (proc && step.has_prim && step.trunc) begin
            r_pend <= 1'b1;
        end
    end

    hcd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (out_word)
    );

    assign o_data_byte    = out_word.data_byte;
    assign o_kind         = out_word.kind;
    assign o_total_length = out_word.total_length;
    assign o_run_last     = out_word.run_last;

endmodule

`default_nettype wire

/* hw/rtl/hcd_chk.sv */
// port-level checks for the chunked body decoder, bound to the top level
// depends on hcd_pkg and http_chunked_decoder
`default_nettype none

module hcd_chk
    import hcd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_data_byte,
    input wire logic [1:0]  o_kind,
    input wire logic [31:0] o_total_length,
    input wire logic        o_run_last
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_byte) && $stable(o_kind)
            && $stable(o_total_length) && $stable(o_run_last))
        else $error("stalled result word changed");

    // only data words carry a payload byte
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_DATA |-> o_data_byte == 8'd0)
        else $error("non-data word with payload byte");

    // end, bad and truncated words always close their byte's run
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_END || o_kind == K_BAD || o_kind == K_TRUNC)
            |-> o_run_last)
        else $error("terminal word without run_last");

    // a data word never reports a zero running length
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_DATA |-> o_total_length != 32'd0)
        else $error("data word with zero length");

endmodule

bind http_chunked_decoder hcd_chk u_hcd_chk (.*);

`default_nettype wire
